// ===== rtl/mip_chain_layout_core_macros.svh =====
// Assertion macros shared by the mip chain layout RTL.
`ifndef MIP_CHAIN_LAYOUT_CORE_MACROS_SVH
`define MIP_CHAIN_LAYOUT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MCL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MCL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mcl_pkg.sv =====
// Types and constants shared by the mip chain layout modules.
`default_nettype none
package mcl_pkg;

  localparam int DIM_W    = 16;
  localparam int NUM_W    = 17;
  localparam int BLK_W    = 5;
  localparam int CNT_IN_W = 5;
  localparam int UNIT_W   = 6;
  localparam int LVL_W    = 4;
  localparam int PITCH_W  = 23;
  localparam int OPITCH_W = 22;
  localparam int RD_W     = 33;
  localparam int SIZE_W   = 56;
  localparam int ACC_W    = 62;
  localparam int OUT_W    = 53;

  localparam logic [OUT_W-1:0] SAT_MAX = {OUT_W{1'b1}};

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [DIM_W-1:0]  depth;
    logic              comp;
    logic [UNIT_W-1:0] unit;
    logic              first;
    logic              last;
  } mcl_side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_c;
    logic [BLK_W-1:0] dv_c;
    logic [NUM_W-1:0] num_r;
    logic [BLK_W-1:0] dv_r;
  } mcl_div_in_t;

endpackage
`default_nettype wire

// ===== rtl/mcl_seq.sv =====
// Level sequencer: takes a description and issues its levels one per cycle while en.
`default_nettype none
module mcl_seq #(
  parameter int MAX_LEVELS = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [mcl_pkg::DIM_W-1:0]     in_base_width,
  input  wire  [mcl_pkg::DIM_W-1:0]     in_base_height,
  input  wire  [mcl_pkg::DIM_W-1:0]     in_base_depth,
  input  wire  [mcl_pkg::CNT_IN_W-1:0]  in_level_count,
  input  wire                           in_compressed,
  input  wire  [mcl_pkg::BLK_W-1:0]     in_block_w,
  input  wire  [mcl_pkg::BLK_W-1:0]     in_block_h,
  input  wire  [mcl_pkg::UNIT_W-1:0]    in_unit_bytes,
  output logic                          iss_vld,
  output mcl_pkg::mcl_side_t            iss_side,
  output mcl_pkg::mcl_div_in_t          iss_div
);
  import mcl_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  idx_r, cnt_r, cnt_nxt;
  logic [DIM_W-1:0]  w_r, h_r, d_r;
  logic              comp_r;
  logic [BLK_W-1:0]  bw_r, bh_r;
  logic [UNIT_W-1:0] unit_r;
  logic              last_lvl;
  logic              vld_r;
  mcl_side_t         side_r, side_nxt;
  mcl_div_in_t       div_r, div_nxt;

  function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(1)) ? (v >> 1) : DIM_W'(1);
  endfunction

  assign in_ready = !busy_r;
  assign last_lvl = (idx_r == cnt_r - CNT_W'(1));

  always_comb begin
    if (in_level_count == '0) begin
      cnt_nxt = CNT_W'(1);
    end else if (32'(in_level_count) > MAX_LEVELS) begin
      cnt_nxt = CNT_W'(MAX_LEVELS);
    end else begin
      cnt_nxt = CNT_W'(in_level_count);
    end
  end

  always_comb begin
    side_nxt.level  = LVL_W'(idx_r);
    side_nxt.width  = w_r;
    side_nxt.height = h_r;
    side_nxt.depth  = d_r;
    side_nxt.comp   = comp_r;
    side_nxt.unit   = unit_r;
    side_nxt.first  = (idx_r == '0);
    side_nxt.last   = last_lvl;
    if (comp_r) begin
      div_nxt.num_c = {1'b0, w_r} + NUM_W'(bw_r) - NUM_W'(1);
      div_nxt.dv_c  = bw_r;
      div_nxt.num_r = {1'b0, h_r} + NUM_W'(bh_r) - NUM_W'(1);
      div_nxt.dv_r  = bh_r;
    end else begin
      div_nxt.num_c = {1'b0, w_r};
      div_nxt.dv_c  = BLK_W'(1);
      div_nxt.num_r = {1'b0, h_r};
      div_nxt.dv_r  = BLK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      if (!busy_r) begin
        if (in_valid) begin
          busy_r <= 1'b1;
        end
      end else if (en && last_lvl) begin
        busy_r <= 1'b0;
      end
      if (en) begin
        vld_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && in_valid) begin
      idx_r  <= '0;
      cnt_r  <= cnt_nxt;
      w_r    <= in_base_width;
      h_r    <= in_base_height;
      d_r    <= in_base_depth;
      comp_r <= in_compressed;
      bw_r   <= (in_block_w == '0) ? BLK_W'(1) : in_block_w;
      bh_r   <= (in_block_h == '0) ? BLK_W'(1) : in_block_h;
      unit_r <= in_unit_bytes;
    end else if (busy_r && en) begin
      idx_r <= idx_r + CNT_W'(1);
      w_r   <= halve(w_r);
      h_r   <= halve(h_r);
      d_r   <= halve(d_r);
    end
    if (busy_r && en) begin
      side_r <= side_nxt;
      div_r  <= div_nxt;
    end
  end

  assign iss_vld  = vld_r;
  assign iss_side = side_r;
  assign iss_div  = div_r;

endmodule
`default_nettype wire

// ===== rtl/mcl_div.sv =====
// Three-stage restoring divider that turns texel counts into block columns and rows.
`default_nettype none
module mcl_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        en,
  input  wire                        in_vld,
  input  mcl_pkg::mcl_side_t         in_side,
  input  mcl_pkg::mcl_div_in_t       in_div,
  output logic                       out_vld,
  output mcl_pkg::mcl_side_t         out_side,
  output logic [mcl_pkg::NUM_W-1:0]  cols,
  output logic [mcl_pkg::NUM_W-1:0]  rows
);
  import mcl_pkg::*;

  localparam int STEPS_A = 6;
  localparam int STEPS_B = 6;
  localparam int STEPS_C = NUM_W - STEPS_A - STEPS_B;

  typedef struct packed {
    logic [BLK_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [BLK_W-1:0] dv;
  } lane_t;

  logic      vld_r  [3];
  mcl_side_t side_r [3];
  lane_t     lc_r [3], lr_r [3];
  lane_t     lc_nxt [3], lr_nxt [3];

  function automatic lane_t div_step(input lane_t l);
    logic [BLK_W:0] t;
    lane_t          o;
    t = {l.rem, l.nq[NUM_W-1]};
    o = l;
    if (t >= {1'b0, l.dv}) begin
      o.rem = BLK_W'(t - {1'b0, l.dv});
      o.nq  = {l.nq[NUM_W-2:0], 1'b1};
    end else begin
      o.rem = t[BLK_W-1:0];
      o.nq  = {l.nq[NUM_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    lc_nxt[0] = '{rem: '0, nq: in_div.num_c, dv: in_div.dv_c};
    lr_nxt[0] = '{rem: '0, nq: in_div.num_r, dv: in_div.dv_r};
    for (int k = 0; k < STEPS_A; k++) begin
      lc_nxt[0] = div_step(lc_nxt[0]);
      lr_nxt[0] = div_step(lr_nxt[0]);
    end
    lc_nxt[1] = lc_r[0];
    lr_nxt[1] = lr_r[0];
    for (int k = 0; k < STEPS_B; k++) begin
      lc_nxt[1] = div_step(lc_nxt[1]);
      lr_nxt[1] = div_step(lr_nxt[1]);
    end
    lc_nxt[2] = lc_r[1];
    lr_nxt[2] = lr_r[1];
    for (int k = 0; k < STEPS_C; k++) begin
      lc_nxt[2] = div_step(lc_nxt[2]);
      lr_nxt[2] = div_step(lr_nxt[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
      vld_r[1] <= 1'b0;
      vld_r[2] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      for (int s = 0; s < 3; s++) begin
        lc_r[s] <= lc_nxt[s];
        lr_r[s] <= lr_nxt[s];
      end
    end
  end

  assign out_vld  = vld_r[2];
  assign out_side = side_r[2];
  assign cols     = lc_r[2].nq;
  assign rows     = lr_r[2].nq;

endmodule
`default_nettype wire

// ===== rtl/mcl_size.sv =====
// Size stages: pitch and products, level size, then running offset and the output register.
`default_nettype none
module mcl_size (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire                           in_vld,
  input  mcl_pkg::mcl_side_t            in_side,
  input  wire  [mcl_pkg::NUM_W-1:0]     cols,
  input  wire  [mcl_pkg::NUM_W-1:0]     rows,
  output logic                          out_vld,
  output mcl_pkg::mcl_side_t            out_side,
  output logic [mcl_pkg::OPITCH_W-1:0]  out_pitch,
  output logic [mcl_pkg::OUT_W-1:0]     out_size,
  output logic [mcl_pkg::OUT_W-1:0]     out_offset,
  output logic [mcl_pkg::OUT_W-1:0]     out_chain
);
  import mcl_pkg::*;

  logic               vld_a_r, vld_b_r, vld_o_r;
  mcl_side_t          side_a_r, side_b_r, side_o_r;
  logic [NUM_W-1:0]   cols_eff, rows_eff;
  logic [PITCH_W-1:0] pitch_a_r, pitch_b_r;
  logic [RD_W-1:0]    rd_a_r;
  logic [SIZE_W-1:0]  size_b_r, size_nxt;
  logic [ACC_W-1:0]   acc_r, base, sum;
  logic [OPITCH_W-1:0] pitch_o_r;
  logic [OUT_W-1:0]   size_o_r, off_o_r, chain_o_r;

  function automatic logic [OUT_W-1:0] sat(input logic [ACC_W-1:0] v);
    return (v > ACC_W'(SAT_MAX)) ? SAT_MAX : v[OUT_W-1:0];
  endfunction

  // A compressed level always spans at least one block in each direction.
  assign cols_eff = (in_side.comp && cols == '0) ? NUM_W'(1) : cols;
  assign rows_eff = (in_side.comp && rows == '0) ? NUM_W'(1) : rows;

  assign size_nxt = SIZE_W'(pitch_a_r) * SIZE_W'(rd_a_r);
  assign base     = side_b_r.first ? '0 : acc_r;
  assign sum      = base + ACC_W'(size_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_o_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
      vld_o_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a_r  <= in_side;
      pitch_a_r <= PITCH_W'(cols_eff) * PITCH_W'(in_side.unit);
      rd_a_r    <= RD_W'(rows_eff) * RD_W'(in_side.depth);
      side_b_r  <= side_a_r;
      pitch_b_r <= pitch_a_r;
      size_b_r  <= size_nxt;
      side_o_r  <= side_b_r;
      pitch_o_r <= pitch_b_r[OPITCH_W-1:0];
      size_o_r  <= sat(ACC_W'(size_b_r));
      off_o_r   <= sat(base);
      chain_o_r <= side_b_r.last ? sat(sum) : '0;
      if (vld_b_r) begin
        acc_r <= sum;
      end
    end
  end

  assign out_vld    = vld_o_r;
  assign out_side   = side_o_r;
  assign out_pitch  = pitch_o_r;
  assign out_size   = size_o_r;
  assign out_offset = off_o_r;
  assign out_chain  = chain_o_r;

endmodule
`default_nettype wire

// ===== rtl/mip_chain_layout_core.sv =====
// Top level of the mip chain layout block: sequencer, block divider and size stages.
`default_nettype none
`include "mip_chain_layout_core_macros.svh"
// A texture description is taken when in_ready is high; the sequencer then issues one
// mip level per cycle while the output does not stall. Each level passes the sequencer
// register, three divider stages and three size stages, and levels leave one per cycle
// while the output does not stall. The sequencer, which steps through the levels of
// one description, sets the rate; the divider and size stages behind it take a new
// level in every cycle that the output does not stall. A stall on the output freezes
// every stage, so no level is lost or repeated. Sizes and offsets are exact and
// saturate at 2^53-1; pitch is given modulo 2^22.
module mip_chain_layout_core #(
  parameter int MAX_LEVELS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [mcl_pkg::DIM_W-1:0]      in_base_width,
  input  wire  [mcl_pkg::DIM_W-1:0]      in_base_height,
  input  wire  [mcl_pkg::DIM_W-1:0]      in_base_depth,
  input  wire  [mcl_pkg::CNT_IN_W-1:0]   in_level_count,
  input  wire                            in_compressed,
  input  wire  [mcl_pkg::BLK_W-1:0]      in_block_w,
  input  wire  [mcl_pkg::BLK_W-1:0]      in_block_h,
  input  wire  [mcl_pkg::UNIT_W-1:0]     in_unit_bytes,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [mcl_pkg::LVL_W-1:0]      out_level,
  output logic [mcl_pkg::DIM_W-1:0]      out_level_width,
  output logic [mcl_pkg::DIM_W-1:0]      out_level_height,
  output logic [mcl_pkg::DIM_W-1:0]      out_level_depth,
  output logic [mcl_pkg::OPITCH_W-1:0]   out_pitch,
  output logic [mcl_pkg::OUT_W-1:0]      out_level_size,
  output logic [mcl_pkg::OUT_W-1:0]      out_level_offset,
  output logic                           out_last,
  output logic [mcl_pkg::OUT_W-1:0]      out_chain_bytes
);
  import mcl_pkg::*;

  logic             en;
  logic             iss_vld, div_vld;
  mcl_side_t        iss_side, div_side, out_side;
  mcl_div_in_t      iss_div;
  logic [NUM_W-1:0] cols, rows;

  assign en = !out_valid || out_ready;

  mcl_seq #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_base_width  (in_base_width),
    .in_base_height (in_base_height),
    .in_base_depth  (in_base_depth),
    .in_level_count (in_level_count),
    .in_compressed  (in_compressed),
    .in_block_w     (in_block_w),
    .in_block_h     (in_block_h),
    .in_unit_bytes  (in_unit_bytes),
    .iss_vld        (iss_vld),
    .iss_side       (iss_side),
    .iss_div        (iss_div)
  );

  mcl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (iss_vld),
    .in_side  (iss_side),
    .in_div   (iss_div),
    .out_vld  (div_vld),
    .out_side (div_side),
    .cols     (cols),
    .rows     (rows)
  );

  mcl_size u_size (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (div_vld),
    .in_side    (div_side),
    .cols       (cols),
    .rows       (rows),
    .out_vld    (out_valid),
    .out_side   (out_side),
    .out_pitch  (out_pitch),
    .out_size   (out_level_size),
    .out_offset (out_level_offset),
    .out_chain  (out_chain_bytes)
  );

  assign out_level        = out_side.level;
  assign out_level_width  = out_side.width;
  assign out_level_height = out_side.height;
  assign out_level_depth  = out_side.depth;
  assign out_last         = out_side.last;

  `MCL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "sequencer took a new item without starting its levels")
  `MCL_ASSERT_IMP(a_chain_only_last, out_valid && !out_last, out_chain_bytes == '0,
    "chain total shown on a level that is not the last")
  `MCL_ASSERT_IMP(a_chain_sum,
    out_valid && out_last && out_chain_bytes != SAT_MAX,
    (OUT_W + 1)'(out_level_offset) + (OUT_W + 1)'(out_level_size)
      == (OUT_W + 1)'(out_chain_bytes),
    "chain total differs from last offset plus last size")

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the mip chain layout block, with its own layout predictor.
`timescale 1ns / 100ps

module tb_top;
  import mcl_pkg::*;

  localparam int LEVEL_LIMIT = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 250;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [DIM_W-1:0]    depth;
    logic [CNT_IN_W-1:0] level_count;
    logic                compressed;
    logic [BLK_W-1:0]    block_w;
    logic [BLK_W-1:0]    block_h;
    logic [UNIT_W-1:0]   unit_bytes;
  } tex_desc_t;

  typedef struct packed {
    logic [LVL_W-1:0]    level;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [DIM_W-1:0]    depth;
    logic [OPITCH_W-1:0] pitch;
    logic [OUT_W-1:0]    size;
    logic [OUT_W-1:0]    offset;
    logic                last;
    logic [OUT_W-1:0]    chain_bytes;
  } level_layout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [DIM_W-1:0]    in_base_width = '0;
  logic [DIM_W-1:0]    in_base_height = '0;
  logic [DIM_W-1:0]    in_base_depth = '0;
  logic [CNT_IN_W-1:0] in_level_count = '0;
  logic                in_compressed = 1'b0;
  logic [BLK_W-1:0]    in_block_w = '0;
  logic [BLK_W-1:0]    in_block_h = '0;
  logic [UNIT_W-1:0]   in_unit_bytes = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LVL_W-1:0]    out_level;
  logic [DIM_W-1:0]    out_level_width;
  logic [DIM_W-1:0]    out_level_height;
  logic [DIM_W-1:0]    out_level_depth;
  logic [OPITCH_W-1:0] out_pitch;
  logic [OUT_W-1:0]    out_level_size;
  logic [OUT_W-1:0]    out_level_offset;
  logic                out_last;
  logic [OUT_W-1:0]    out_chain_bytes;

  level_layout_t pending_levels[$];

  int unsigned mismatch_count = 0;
  int unsigned descs_sent = 0;
  int unsigned compressed_descs = 0;
  int unsigned levels_seen = 0;
  int unsigned saturated_levels = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_stall = 0;
  bit rx_jitter = 1'b0;
  bit tx_jitter = 1'b0;

  mip_chain_layout_core #(
    .MAX_LEVELS(LEVEL_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_base_width(in_base_width),
    .in_base_height(in_base_height),
    .in_base_depth(in_base_depth),
    .in_level_count(in_level_count),
    .in_compressed(in_compressed),
    .in_block_w(in_block_w),
    .in_block_h(in_block_h),
    .in_unit_bytes(in_unit_bytes),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_level(out_level),
    .out_level_width(out_level_width),
    .out_level_height(out_level_height),
    .out_level_depth(out_level_depth),
    .out_pitch(out_pitch),
    .out_level_size(out_level_size),
    .out_level_offset(out_level_offset),
    .out_last(out_last),
    .out_chain_bytes(out_chain_bytes)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [OUT_W-1:0] clip_size(input logic [63:0] v);
    return (v > SAT_MAX) ? SAT_MAX : v[OUT_W-1:0];
  endfunction

  function automatic void predict_chain(input tex_desc_t t);
    logic [63:0] w, h, d, bw, bh, unit, cols, rows, pitch, size, offset;
    int unsigned levels;
    level_layout_t lay;
    w = t.width;
    h = t.height;
    d = t.depth;
    bw = (t.block_w == 0) ? 64'd1 : 64'(t.block_w);
    bh = (t.block_h == 0) ? 64'd1 : 64'(t.block_h);
    unit = t.unit_bytes;
    levels = t.level_count;
    if (levels == 0) levels = 1;
    if (levels > LEVEL_LIMIT) levels = LEVEL_LIMIT;
    offset = 0;
    for (int unsigned i = 0; i < levels; i++) begin
      if (t.compressed) begin
        cols = (w + bw - 1) / bw;
        rows = (h + bh - 1) / bh;
        if (cols == 0) cols = 1;
        if (rows == 0) rows = 1;
      end else begin
        cols = w;
        rows = h;
      end
      pitch = cols * unit;
      size = pitch * rows * d;
      lay.level = LVL_W'(i);
      lay.width = w[DIM_W-1:0];
      lay.height = h[DIM_W-1:0];
      lay.depth = d[DIM_W-1:0];
      lay.pitch = pitch[OPITCH_W-1:0];
      lay.size = clip_size(size);
      lay.offset = clip_size(offset);
      offset += size;
      lay.last = (i + 1 == levels);
      lay.chain_bytes = lay.last ? clip_size(offset) : '0;
      if (size > SAT_MAX) saturated_levels++;
      pending_levels.push_back(lay);
      w = (w > 1) ? (w >> 1) : 64'd1;
      h = (h > 1) ? (h >> 1) : 64'd1;
      d = (d > 1) ? (d >> 1) : 64'd1;
    end
  endfunction

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic int unsigned next_tx_gap();
    return (tx_jitter && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    case ($urandom_range(0, 3))
      0: return DIM_W'($urandom_range(1, 16));
      1: return DIM_W'($urandom_range(1, 1024));
      2: return DIM_W'(1 << $urandom_range(0, 15));
      default: return DIM_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic tex_desc_t random_desc();
    tex_desc_t t;
    if ($urandom_range(0, 9) == 0) begin
      t.width = DIM_W'($urandom_range(0, 65535));
      t.height = DIM_W'($urandom_range(0, 65535));
      t.depth = DIM_W'($urandom_range(0, 65535));
      t.level_count = CNT_IN_W'($urandom_range(0, 31));
      t.compressed = 1'($urandom_range(0, 1));
      t.block_w = BLK_W'($urandom_range(0, 31));
      t.block_h = BLK_W'($urandom_range(0, 31));
      t.unit_bytes = UNIT_W'($urandom_range(0, 63));
    end else begin
      t.width = random_dim();
      t.height = random_dim();
      t.depth = ($urandom_range(0, 2) == 0) ? random_dim() : DIM_W'(1);
      t.level_count = CNT_IN_W'($urandom_range(1, 16));
      t.compressed = 1'($urandom_range(0, 1));
      t.block_w = ($urandom_range(0, 1) == 0) ? BLK_W'(4) : BLK_W'($urandom_range(1, 16));
      t.block_h = ($urandom_range(0, 1) == 0) ? BLK_W'(4) : BLK_W'($urandom_range(1, 16));
      t.unit_bytes = UNIT_W'($urandom_range(1, 32));
    end
    return t;
  endfunction

  task automatic send_desc(input tex_desc_t t, input int unsigned gap);
    in_valid <= 1'b1;
    in_base_width <= t.width;
    in_base_height <= t.height;
    in_base_depth <= t.depth;
    in_level_count <= t.level_count;
    in_compressed <= t.compressed;
    in_block_w <= t.block_w;
    in_block_h <= t.block_h;
    in_unit_bytes <= t.unit_bytes;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_chain(t);
    descs_sent++;
    if (t.compressed) compressed_descs++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_levels();
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic note_field(input string field, input int unsigned lvl,
                            input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("Mismatch on %s at level %0d: expected %0d, got %0d", field, lvl, want, got);
    end
  endtask

  always @(posedge clk) begin
    level_layout_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      levels_seen++;
      if (pending_levels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("Unexpected level item: level %0d, size %0d", out_level, out_level_size);
      end else begin
        want = pending_levels.pop_front();
        note_field("level", want.level, want.level, out_level);
        note_field("level_width", want.level, want.width, out_level_width);
        note_field("level_height", want.level, want.height, out_level_height);
        note_field("level_depth", want.level, want.depth, out_level_depth);
        note_field("pitch", want.level, want.pitch, out_pitch);
        note_field("level_size", want.level, want.size, out_level_size);
        note_field("level_offset", want.level, want.offset, out_level_offset);
        note_field("last", want.level, want.last, out_last);
        note_field("chain_bytes", want.level, want.chain_bytes, out_chain_bytes);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        rx_stall = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_stall == 0 && rx_jitter && $urandom_range(0, 5) == 0) begin
        rx_stall = pick_gap();
      end
      if (rx_stall != 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no item moved for %0d cycles, %0d levels outstanding",
             IDLE_LIMIT, pending_levels.size());
    $display("CHECK FAILED");
    $finish;
  end

  task automatic test_directed_cases();
    tex_desc_t cases[$];
    cases.push_back('{1, 1, 1, 1, 0, 1, 1, 1});
    cases.push_back('{65535, 65535, 1, 16, 0, 1, 1, 32});
    cases.push_back('{65535, 65535, 65535, 16, 0, 1, 1, 63});
    cases.push_back('{65535, 65535, 65535, 16, 1, 1, 1, 63});
    cases.push_back('{100, 50, 1, 0, 0, 1, 1, 4});
    cases.push_back('{300, 200, 7, 31, 0, 1, 1, 4});
    cases.push_back('{512, 256, 1, 17, 1, 4, 4, 16});
    cases.push_back('{64, 64, 1, 8, 1, 0, 0, 16});
    cases.push_back('{1023, 513, 1, 11, 1, 4, 4, 8});
    cases.push_back('{5, 3, 1, 4, 1, 16, 16, 16});
    cases.push_back('{65535, 1000, 2, 16, 1, 5, 3, 32});
    cases.push_back('{0, 0, 0, 3, 0, 1, 1, 4});
    cases.push_back('{0, 0, 0, 3, 1, 4, 4, 8});
    cases.push_back('{64, 32, 4, 7, 0, 1, 1, 0});
    cases.push_back('{40000, 12345, 3, 16, 1, 31, 31, 63});
    cases.push_back('{1, 1, 65535, 16, 0, 1, 1, 1});
    cases.push_back('{4096, 4096, 1, 13, 1, 12, 10, 16});
    foreach (cases[i]) send_desc(cases[i], 0);
    release_input();
  endtask

  task automatic test_back_to_back();
    repeat (30) send_desc(random_desc(), 0);
    release_input();
  endtask

  task automatic test_output_hold();
    rx_hold_req = HOLD_CYCLES;
    repeat (20) send_desc(random_desc(), 0);
    release_input();
  endtask

  task automatic test_drain_pauses();
    repeat (6) begin
      wait_for_levels();
      send_desc(random_desc(), 1);
    end
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 230; i++) begin
      if (i % 40 == 0) begin
        rx_jitter = ($urandom_range(0, 3) != 0);
        tx_jitter = ($urandom_range(0, 3) != 0);
      end
      send_desc(random_desc(), next_tx_gap());
    end
    release_input();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_back_to_back();
    test_output_hold();
    test_drain_pauses();
    test_random_traffic();
    wait_for_levels();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d texture descriptions (%0d block compressed), %0d mip levels.",
             descs_sent, compressed_descs, levels_seen);
    $display("Levels with a saturated size: %0d; mismatches found: %0d.",
             saturated_levels, mismatch_count);
    if (mismatch_count == 0 && pending_levels.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
